@@ design/bcas_pkg.sv @@
// Shared types and constants for the bounds-checked array store.
// Used by bcas_front, bcas_fifo, bcas_back and bounds_checked_array_store_top.
`default_nettype none

package bcas_pkg;

	localparam int ARRAY_COUNT    = 16;
	localparam int ARRAY_CAPACITY = 1024;
	localparam int STORE_DEPTH    = ARRAY_COUNT * ARRAY_CAPACITY;

	localparam int ARR_W  = (ARRAY_COUNT > 1) ? $clog2(ARRAY_COUNT) : 1;
	localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [1:0] CMD_DIM   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       wdata;
		logic              status;
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} back_state_t;

endpackage

`default_nettype wire

@@ design/bcas_front.sv @@
// Front end: takes command beats, keeps the descriptor table, runs all checks
// and builds the element address. Depends on bcas_pkg.
`default_nettype none

module bcas_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           cmd,
	input  wire logic [7:0]           array_number,
	input  wire logic signed [15:0]   first_index,
	input  wire logic signed [15:0]   second_index,
	input  wire logic signed [31:0]   write_value,
	input  wire logic                 q_full,
	input  wire logic                 clearing,
	output logic                      push,
	output bcas_pkg::op_t             push_op
);

	logic       in_use_q  [bcas_pkg::ARRAY_COUNT];
	logic       two_dim_q [bcas_pkg::ARRAY_COUNT];
	logic [7:0] size1_q   [bcas_pkg::ARRAY_COUNT];
	logic [7:0] size2_q   [bcas_pkg::ARRAY_COUNT];

	logic [bcas_pkg::ARR_W-1:0] idx;
	logic                       arr_ok;
	logic                       a_ok;
	logic                       b_ok;
	logic                       pos_ok;
	logic                       loc_ok;
	logic                       b_pos;
	logic [15:0]                prod;
	logic [15:0]                pos;
	logic [7:0]                 s1;
	logic [7:0]                 s2;

	assign in_ready = !q_full && !clearing;
	assign push     = in_valid && in_ready;

	always_comb begin
		idx    = array_number[bcas_pkg::ARR_W-1:0];
		arr_ok = {1'b0, array_number} < 9'(bcas_pkg::ARRAY_COUNT);
		s1     = size1_q[idx];
		s2     = size2_q[idx];
		a_ok   = !first_index[15] && (16'(first_index) < {8'h00, s1});
		b_ok   = !second_index[15] && (16'(second_index) < {8'h00, s2});
		prod   = 16'(first_index[7:0]) * 16'(s2);
		if (two_dim_q[idx]) begin
			pos = prod + {8'h00, second_index[7:0]};
		end else begin
			pos = {8'h00, first_index[7:0]};
		end
		pos_ok = {1'b0, pos} < 17'(bcas_pkg::ARRAY_CAPACITY);
		loc_ok = arr_ok && in_use_q[idx] && a_ok && (!two_dim_q[idx] || b_ok) && pos_ok;
		b_pos  = !second_index[15] && (second_index != 16'sd0);

		push_op.addr  = bcas_pkg::ADDR_W'(idx) * bcas_pkg::ADDR_W'(bcas_pkg::ARRAY_CAPACITY)
			+ bcas_pkg::ADDR_W'(pos);
		push_op.wdata = write_value;
		case (cmd)
			bcas_pkg::CMD_DIM: begin
				push_op.kind   = bcas_pkg::OP_NONE;
				push_op.status = !arr_ok;
			end
			bcas_pkg::CMD_READ: begin
				push_op.kind   = loc_ok ? bcas_pkg::OP_READ : bcas_pkg::OP_NONE;
				push_op.status = !loc_ok;
			end
			bcas_pkg::CMD_WRITE: begin
				push_op.kind   = loc_ok ? bcas_pkg::OP_WRITE : bcas_pkg::OP_NONE;
				push_op.status = !loc_ok;
			end
			default: begin
				push_op.kind   = bcas_pkg::OP_NONE;
				push_op.status = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bcas_pkg::ARRAY_COUNT; i++) begin
				in_use_q[i]  <= 1'b0;
				two_dim_q[i] <= 1'b0;
				size1_q[i]   <= 8'h00;
				size2_q[i]   <= 8'h00;
			end
		end else if (push && (cmd == bcas_pkg::CMD_DIM) && arr_ok) begin
			in_use_q[idx]  <= 1'b1;
			size1_q[idx]   <= first_index[7:0];
			two_dim_q[idx] <= b_pos;
			size2_q[idx]   <= b_pos ? second_index[7:0] : 8'h00;
		end
	end

endmodule

`default_nettype wire

@@ design/bcas_fifo.sv @@
// Short queue of checked operations between front and back end.
// Depends on bcas_pkg.
`default_nettype none

module bcas_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire bcas_pkg::op_t push_op,
	input  wire logic          pop,
	output bcas_pkg::op_t      head_op,
	output logic               full,
	output logic               empty
);

	bcas_pkg::op_t                   entry_q [bcas_pkg::FIFO_DEPTH];
	logic [bcas_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [bcas_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [bcas_pkg::FIFO_CNT_W-1:0] count_q;

	assign head_op = entry_q[rd_ptr_q];
	assign full    = count_q == bcas_pkg::FIFO_CNT_W'(bcas_pkg::FIFO_DEPTH);
	assign empty   = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/bcas_back.sv @@
// Back end: element store with its post-reset clearing sweep, at most one access per
// popped operation, and the result register. Depends on bcas_pkg.
`default_nettype none

module bcas_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bcas_pkg::op_t       head_op,
	input  wire logic                q_empty,
	output logic                     pop,
	output logic                     clearing,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [31:0]       read_value,
	output logic                     status
);

	logic [31:0]                 mem_q [bcas_pkg::STORE_DEPTH];
	logic [31:0]                 rdata_q;
	bcas_pkg::back_state_t       state_q;
	logic [bcas_pkg::ADDR_W-1:0] clr_idx_q;
	logic                        valid_s1;
	logic                        status_s1;
	logic                        rd_sel_s1;

	logic                        we;
	logic [bcas_pkg::ADDR_W-1:0] waddr;
	logic [31:0]                 wdata;

	assign clearing   = state_q == bcas_pkg::ST_CLEAR;
	assign pop        = (state_q == bcas_pkg::ST_RUN) && !q_empty && (!valid_s1 || out_ready);
	assign out_valid  = valid_s1;
	assign status     = status_s1;
	assign read_value = rd_sel_s1 ? rdata_q : 32'h0;

	always_comb begin
		if (clearing) begin
			we    = 1'b1;
			waddr = clr_idx_q;
			wdata = 32'h0;
		end else begin
			we    = pop && (head_op.kind == bcas_pkg::OP_WRITE);
			waddr = head_op.addr;
			wdata = head_op.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (pop && (head_op.kind == bcas_pkg::OP_READ)) begin
			rdata_q <= mem_q[head_op.addr];
		end
		if (pop) begin
			status_s1 <= head_op.status;
			rd_sel_s1 <= head_op.kind == bcas_pkg::OP_READ;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bcas_pkg::ST_CLEAR;
			clr_idx_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			case (state_q)
				bcas_pkg::ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == bcas_pkg::ADDR_W'(bcas_pkg::STORE_DEPTH - 1)) begin
						state_q <= bcas_pkg::ST_RUN;
					end
				end
				bcas_pkg::ST_RUN: begin
					if (pop) begin
						valid_s1 <= 1'b1;
					end else if (out_ready) begin
						valid_s1 <= 1'b0;
					end
				end
				default: begin
					state_q <= bcas_pkg::ST_CLEAR;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/bounds_checked_array_store_top.sv @@
// Top level of the bounds-checked array store: stream ports, front end, queue, back end.
// Depends on bcas_pkg, bcas_front, bcas_fifo, bcas_back.
// Path: a beat goes through the queue and the result register to the master side.
// Throughput: one command per cycle while the queue has room, outside the clear sweep;
// the store does at most one access per cycle. Reset: descriptors clear at once;
// all ARRAY_COUNT * ARRAY_CAPACITY store words are swept to zero with s_axis_tready low.
`default_nettype none

module bounds_checked_array_store_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [1:0] cmd, [9:2] array_number, [25:10] first_index, [41:26] second_index,
	// [73:42] write_value, [79:74] zero
	input  wire logic [79:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [31:0] read_value, [32] status, [39:33] zero
	output logic [39:0]      m_axis_tdata
);

	bcas_pkg::op_t     push_op;
	bcas_pkg::op_t     head_op;
	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_empty;
	logic              clearing;
	logic signed [31:0] read_value;
	logic              status;

	bcas_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.cmd          (s_axis_tdata[1:0]),
		.array_number (s_axis_tdata[9:2]),
		.first_index  (s_axis_tdata[25:10]),
		.second_index (s_axis_tdata[41:26]),
		.write_value  (s_axis_tdata[73:42]),
		.q_full       (q_full),
		.clearing     (clearing),
		.push         (push),
		.push_op      (push_op)
	);

	bcas_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.full    (q_full),
		.empty   (q_empty)
	);

	bcas_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_op    (head_op),
		.q_empty    (q_empty),
		.pop        (pop),
		.clearing   (clearing),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.read_value (read_value),
		.status     (status)
	);

	assign m_axis_tdata = {7'h00, status, read_value};

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !s_axis_tready)
		else $error("beat accepted during store clear");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!q_full || pop))
		else $error("queue overflow");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from empty queue");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && status) |-> (read_value == 32'sd0))
		else $error("rejected beat carries nonzero data");

endmodule

`default_nettype wire

@@ dv/bounds_checked_array_store_top_test.sv @@
// Self-checking testbench for bounds_checked_array_store_top: directed corner cases,
// back-to-back traffic, output backpressure and random commands checked against a predictor.
// Depends on bcas_pkg and the bounds_checked_array_store_top RTL.
`timescale 1ns / 1ps

module bounds_checked_array_store_top_test;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 8;

	typedef struct packed {
		logic [31:0] read_value;
		logic        status;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;

	// predictor state
	logic        dim_used  [bcas_pkg::ARRAY_COUNT];
	logic        dim_is_2d [bcas_pkg::ARRAY_COUNT];
	logic [7:0]  dim_rows  [bcas_pkg::ARRAY_COUNT];
	logic [7:0]  dim_cols  [bcas_pkg::ARRAY_COUNT];
	logic [31:0] element_mem [bcas_pkg::STORE_DEPTH];

	result_t pending_results [$];
	int      err_count;
	int      beat_count;
	int      burst_left;
	bit      gaps_on;
	bit      hold_req;

	bounds_checked_array_store_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#CLK_HALF clk = ~clk;
		end
	end

	function automatic void clear_store_model();
		foreach (dim_used[i]) begin
			dim_used[i]  = 1'b0;
			dim_is_2d[i] = 1'b0;
			dim_rows[i]  = '0;
			dim_cols[i]  = '0;
		end
		foreach (element_mem[i])
			element_mem[i] = '0;
	endfunction

	function automatic bit locate_element(input logic [7:0] arr, input logic signed [15:0] a,
			input logic signed [15:0] b, output int unsigned slot);
		int ai;
		int bi;
		int unsigned pos;
		ai = a;
		bi = b;
		slot = 0;
		if (arr >= bcas_pkg::ARRAY_COUNT || !dim_used[arr])
			return 0;
		if (ai < 0 || ai >= int'(dim_rows[arr]))
			return 0;
		if (dim_is_2d[arr]) begin
			if (bi < 0 || bi >= int'(dim_cols[arr]))
				return 0;
			pos = ai * dim_cols[arr] + bi;
		end else begin
			pos = ai;
		end
		if (pos >= bcas_pkg::ARRAY_CAPACITY)
			return 0;
		slot = arr * bcas_pkg::ARRAY_CAPACITY + pos;
		return 1;
	endfunction

	function automatic result_t apply_command(input logic [1:0] cmd, input logic [7:0] arr,
			input logic signed [15:0] a, input logic signed [15:0] b, input logic [31:0] v);
		result_t r;
		int unsigned slot;
		r.read_value = '0;
		r.status     = 1'b1;
		case (cmd)
			bcas_pkg::CMD_DIM: begin
				if (arr < bcas_pkg::ARRAY_COUNT) begin
					dim_used[arr] = 1'b1;
					dim_rows[arr] = a[7:0];
					if (b > 0) begin
						dim_is_2d[arr] = 1'b1;
						dim_cols[arr]  = b[7:0];
					end else begin
						dim_is_2d[arr] = 1'b0;
						dim_cols[arr]  = '0;
					end
					r.status = 1'b0;
				end
			end
			bcas_pkg::CMD_READ: begin
				if (locate_element(arr, a, b, slot)) begin
					r.read_value = element_mem[slot];
					r.status     = 1'b0;
				end
			end
			bcas_pkg::CMD_WRITE: begin
				if (locate_element(arr, a, b, slot)) begin
					element_mem[slot] = v;
					r.status          = 1'b0;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_error(input string msg);
		$display("[%0t] error on result beat %0d: %s", $realtime, beat_count, msg);
		err_count++;
	endtask

	task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] arr, input logic [15:0] a,
			input logic [15:0] b, input logic [31:0] v);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b0, v, b, a, arr, cmd};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_results.push_back(apply_command(cmd, arr, a, b, v));
		if (gaps_on) begin
			if (burst_left == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(0, 12);
			end else begin
				burst_left--;
			end
		end
	endtask

	// random in-bounds subscript for a dimension, or a value from 0 to 3 when the size is zero
	function automatic logic [15:0] pick_index(input logic [7:0] size);
		if (size == 0)
			return 16'($urandom_range(0, 3));
		return 16'($urandom_range(0, size - 1));
	endfunction

	task automatic dim_random(input logic [7:0] arr);
		logic [15:0] rows;
		logic [15:0] cols;
		case ($urandom_range(0, 9))
			0:       rows = 16'($urandom);
			default: rows = 16'($urandom_range(1, 40));
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2: cols = 16'(-$urandom_range(0, 32768));
			3:       cols = 16'($urandom);
			default: cols = 16'($urandom_range(1, 40));
		endcase
		send_cmd(bcas_pkg::CMD_DIM, arr, rows, cols, $urandom);
	endtask

	task automatic access_random();
		logic [7:0]  arr;
		logic [15:0] a;
		logic [15:0] b;
		logic [31:0] v;
		arr = 8'($urandom_range(0, bcas_pkg::ARRAY_COUNT - 1));
		a   = pick_index(dim_rows[arr]);
		b   = dim_is_2d[arr] ? pick_index(dim_cols[arr]) : 16'($urandom);
		v   = $urandom;
		case ($urandom_range(0, 3))
			0: begin
				send_cmd(bcas_pkg::CMD_WRITE, arr, a, b, v);
				send_cmd(bcas_pkg::CMD_READ, arr, a, b, $urandom);
			end
			1: send_cmd(bcas_pkg::CMD_WRITE, arr, a, b, v);
			default: send_cmd(bcas_pkg::CMD_READ, arr, a, b, v);
		endcase
	endtask

	task automatic noise_random();
		send_cmd(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), 16'($urandom),
			$urandom);
	endtask

	task automatic test_directed_cases();
		send_cmd(bcas_pkg::CMD_READ,   0, 0, 0, 0);
		send_cmd(bcas_pkg::CMD_DIM,    0, 16'h12FF, 0, 0);
		send_cmd(bcas_pkg::CMD_WRITE,  0, 254, 16'h7FFF, 32'h8000_0000);
		send_cmd(bcas_pkg::CMD_READ,   0, 254, 16'h8000, 0);
		send_cmd(bcas_pkg::CMD_WRITE,  0, 5, 0, 32'h7FFF_FFFF);
		send_cmd(bcas_pkg::CMD_READ,   0, 255, 0, 0);
		send_cmd(bcas_pkg::CMD_READ,   0, 16'hFFFF, 0, 0);
		send_cmd(bcas_pkg::CMD_WRITE,  0, 16'h8000, 0, 32'hFFFF_FFFF);
		send_cmd(bcas_pkg::CMD_DIM,    1, 32, 32, 0);
		send_cmd(bcas_pkg::CMD_WRITE,  1, 31, 31, 32'hFFFF_FFFF);
		send_cmd(bcas_pkg::CMD_READ,   1, 31, 31, 0);
		send_cmd(bcas_pkg::CMD_READ,   1, 31, 32, 0);
		// 255 x 255: position check against capacity
		send_cmd(bcas_pkg::CMD_DIM,    2, 255, 16'h7FFF, 0);
		send_cmd(bcas_pkg::CMD_WRITE,  2, 4, 3, 32'h1234_5678);
		send_cmd(bcas_pkg::CMD_WRITE,  2, 4, 4, 32'h5555_AAAA);
		// positive second size with low byte zero: 2-D, no columns
		send_cmd(bcas_pkg::CMD_DIM,    3, 8, 16'h0100, 0);
		send_cmd(bcas_pkg::CMD_WRITE,  3, 0, 0, 1);
		send_cmd(bcas_pkg::CMD_DIM,    4, 8, 16'h8000, 0);
		send_cmd(bcas_pkg::CMD_READ,   4, 7, 16'hFFFF, 0);
		send_cmd(bcas_pkg::CMD_DIM,    16, 8, 0, 0);
		send_cmd(bcas_pkg::CMD_READ,   8'hFF, 0, 0, 0);
		send_cmd(CMD_UNUSED,           0, 5, 0, 0);
		// redimension keeps stored data
		send_cmd(bcas_pkg::CMD_DIM,    0, 10, 0, 0);
		send_cmd(bcas_pkg::CMD_READ,   0, 5, 0, 0);
		send_cmd(bcas_pkg::CMD_DIM,    5, 0, 0, 0);
		send_cmd(bcas_pkg::CMD_READ,   5, 0, 0, 0);
	endtask

	task automatic test_back_to_back(input int n);
		gaps_on = 1'b0;
		for (int i = 0; i < n; i++)
			access_random();
		gaps_on = 1'b1;
	endtask

	task automatic test_backpressure(input int n);
		gaps_on  = 1'b0;
		hold_req = 1'b1;
		for (int i = 0; i < n; i++)
			access_random();
		gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic(input int n);
		int sel;
		for (int i = 0; i < bcas_pkg::ARRAY_COUNT; i++)
			dim_random(8'(i));
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 6)
				dim_random(8'($urandom_range(0, bcas_pkg::ARRAY_COUNT - 1)));
			else if (sel < 22)
				noise_random();
			else
				access_random();
		end
	endtask

	// receiver ready: changing patterns, plus one long hold-off on request
	initial begin
		int rx_mode;
		int rx_left;
		logic [7:0] rx_pattern;
		m_axis_tready = 1'b0;
		rx_mode       = 0;
		rx_left       = 0;
		rx_pattern    = 8'b1011_0010;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (rx_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_left = $urandom_range(20, 120);
				end else begin
					rx_left--;
				end
				rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
				case (rx_mode)
					0:       m_axis_tready <= 1'b1;
					1:       m_axis_tready <= 1'($urandom_range(0, 1));
					2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= rx_pattern[0];
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_error($sformatf("unexpected beat %h", m_axis_tdata));
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[31:0] !== want.read_value)
					report_error($sformatf("read_value %h, want %h",
						m_axis_tdata[31:0], want.read_value));
				if (m_axis_tdata[32] !== want.status)
					report_error($sformatf("status %b, want %b", m_axis_tdata[32], want.status));
				if (m_axis_tdata[39:33] !== '0)
					report_error($sformatf("pad bits %h", m_axis_tdata[39:33]));
			end
			beat_count++;
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("FAIL bounds_checked_array_store_top");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		err_count     = 0;
		beat_count    = 0;
		burst_left    = 4;
		gaps_on       = 1'b1;
		hold_req      = 1'b0;
		clear_store_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_back_to_back(40);
		test_backpressure(50);
		test_random_traffic(420);

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_count == 0)
			$display("PASS bounds_checked_array_store_top");
		else
			$display("FAIL bounds_checked_array_store_top");
		$finish;
	end

endmodule

@@ bounds_checked_array_store_top.f @@
design/bcas_pkg.sv
design/bcas_front.sv
design/bcas_fifo.sv
design/bcas_back.sv
design/bounds_checked_array_store_top.sv
dv/bounds_checked_array_store_top_test.sv
